/* sv/two_level_page_table_manager_unit_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the two-level page table manager
// Shorthand for the clocked, reset-qualified checks used in the RTL.
// ----------------------------------------------------------------------------
`ifndef TWO_LEVEL_PAGE_TABLE_MANAGER_UNIT_MACROS_SVH
`define TWO_LEVEL_PAGE_TABLE_MANAGER_UNIT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PTM_ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define PTM_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* sv/ptm_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ptm_pkg
// Shared sizes, codes and beat types of the two-level page table manager.
// ----------------------------------------------------------------------------
package ptm_pkg;

   // Table pool geometry.
   localparam int TABLE_SLOTS       = 4;
   localparam int ENTRIES_PER_TABLE = 1024;
   localparam int DIR_ENTRIES       = 1024;
   localparam int IDX_W             = $clog2(ENTRIES_PER_TABLE);
   localparam int SLOT_W            = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
   localparam int NSLOT_W           = $clog2(TABLE_SLOTS + 1);
   localparam int POOL_DEPTH        = TABLE_SLOTS * ENTRIES_PER_TABLE;
   localparam int POOL_AW           = $clog2(POOL_DEPTH);
   localparam int DIR_AW            = $clog2(DIR_ENTRIES);

   // Entry layout.
   localparam int ENTRY_W    = 32;
   localparam int FRAME_W    = 20;
   localparam int PAGE_SHIFT = 12;
   localparam int DIR_SHIFT  = 22;
   localparam int BIT_PRESENT = 0;
   localparam int BIT_WRITE   = 1;
   localparam int BIT_USER    = 2;
   // A directory word carries the slot number above the architectural entry.
   localparam int DIR_W = ENTRY_W + SLOT_W;

   // Configuration port.
   localparam int CSR_AW = 3;
   localparam int CSR_DW = 32;
   localparam logic [CSR_AW-3:0] REG_TABLE_POOL_FRAME = 1'b0;
   localparam logic [FRAME_W-1:0] FRAME_RESET = 20'd256;

   typedef enum logic [1:0] {
      OP_MAP    = 2'd0,
      OP_UNMAP  = 2'd1,
      OP_LOOKUP = 2'd2
   } op_type;

   typedef enum logic [1:0] {
      STAT_DONE    = 2'd0,
      STAT_ABSENT  = 2'd1,
      STAT_NO_SLOT = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_DIR,
      S_POOL,
      S_RESP
   } state_type;

   typedef struct packed {
      logic [1:0]  op;
      logic [31:0] virt_addr;
      logic [31:0] phys_addr;
      logic [11:0] page_flags;
   } req_payload_type;

   typedef struct packed {
      logic [31:0] phys_result;
      logic [1:0]  status;
      logic        tlb_invalidate;
      logic [31:0] invalidate_addr;
   } rsp_payload_type;

   // Pool address of one entry of one table slot.
   function automatic logic [POOL_AW-1:0] pool_addr(input logic [SLOT_W-1:0] slot,
                                                    input logic [IDX_W-1:0]  idx);
      logic [SLOT_W+IDX_W-1:0] full;
      full = {slot, idx};
      return full[POOL_AW-1:0];
   endfunction

endpackage
`default_nettype wire

/* sv/two_level_page_table_manager_unit.sv */
`timescale 1ns / 1ps
`default_nettype none
`include "two_level_page_table_manager_unit_macros.svh"
// ----------------------------------------------------------------------------
// two_level_page_table_manager_unit
// Map, unmap and lookup engine over a directory RAM and a page table pool RAM.
// ----------------------------------------------------------------------------
// Usage:
//   The req channel carries one operation per beat (map, unmap or lookup of a
//   virtual address). The rsp channel returns exactly one beat per request
//   with the lookup result, a status code and a TLB invalidate indication.
//   The csr port sets the frame number of the first table slot; write it only
//   while no request is in flight.
//   Map and unmap, and a lookup that finds a present directory entry, go
//   through a directory RAM read, a dependent pool RAM read or write, and
//   the load of the response register. One request is in flight at a
//   time; the next is accepted once the response is registered.
//   After reset the unit sweeps both RAMs to zero, one pool entry per cycle,
//   over all TABLE_SLOTS * 1024 pool entries (4096), with req_stall held
//   high; csr writes are taken during the sweep.
//   A stalled response stays in the output register; the following request
//   may still be accepted and its result waits until the register frees up.
// ----------------------------------------------------------------------------
module two_level_page_table_manager_unit (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_valid,
   output logic                                  req_stall,
   input  wire ptm_pkg::req_payload_type         req_data,
   output logic                                  rsp_valid,
   input  wire logic                             rsp_stall,
   output ptm_pkg::rsp_payload_type              rsp_data,
   input  wire logic                             csr_psel,
   input  wire logic                             csr_penable,
   input  wire logic                             csr_pwrite,
   input  wire logic [ptm_pkg::CSR_AW-1:0]       csr_paddr,
   input  wire logic [ptm_pkg::CSR_DW-1:0]       csr_pwdata,
   output logic      [ptm_pkg::CSR_DW-1:0]       csr_prdata,
   output logic                                  csr_pready
);
   import ptm_pkg::*;

   state_type            state_ff, state_in;
   req_payload_type      item_ff, item_in;
   rsp_payload_type      res_ff, res_in;
   rsp_payload_type      rsp_data_ff, rsp_data_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [POOL_AW-1:0]   clr_ff, clr_in;
   logic [NSLOT_W-1:0]   next_slot_ff, next_slot_in;

   logic [FRAME_W-1:0]   table_pool_frame;

   logic                 dir_we, dir_re;
   logic [DIR_AW-1:0]    dir_waddr, dir_raddr;
   logic [DIR_W-1:0]     dir_wdata, dir_rdata;
   logic                 pool_we, pool_re;
   logic [POOL_AW-1:0]   pool_waddr, pool_raddr;
   logic [ENTRY_W-1:0]   pool_wdata, pool_rdata;

   logic                 rsp_load;
   logic                 dir_present;
   logic [SLOT_W-1:0]    dir_slot;
   logic [SLOT_W-1:0]    new_slot;
   logic [IDX_W-1:0]     tbl_idx;
   logic [FRAME_W-1:0]   new_frame;
   logic [ENTRY_W-1:0]   pte_word;
   logic [ENTRY_W-1:0]   pde_word;
   logic                 slots_full;

   // Configuration register.
   ptm_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_psel         (csr_psel),
      .csr_penable      (csr_penable),
      .csr_pwrite       (csr_pwrite),
      .csr_paddr        (csr_paddr),
      .csr_pwdata       (csr_pwdata),
      .csr_prdata       (csr_prdata),
      .csr_pready       (csr_pready),
      .table_pool_frame (table_pool_frame)
   );

   // Directory RAM: slot number beside each architectural entry.
   ptm_ram #(.DEPTH(DIR_ENTRIES), .WIDTH(DIR_W)) u_dir_ram (
      .clock (clock),
      .we    (dir_we),
      .waddr (dir_waddr),
      .wdata (dir_wdata),
      .re    (dir_re),
      .raddr (dir_raddr),
      .rdata (dir_rdata)
   );

   // Page table pool RAM.
   ptm_ram #(.DEPTH(POOL_DEPTH), .WIDTH(ENTRY_W)) u_pool_ram (
      .clock (clock),
      .we    (pool_we),
      .waddr (pool_waddr),
      .wdata (pool_wdata),
      .re    (pool_re),
      .raddr (pool_raddr),
      .rdata (pool_rdata)
   );

   // Fields decoded from the held request and the directory read.
   assign dir_present = dir_rdata[BIT_PRESENT];
   assign dir_slot    = dir_rdata[DIR_W-1 -: SLOT_W];
   assign new_slot    = next_slot_ff[SLOT_W-1:0];
   assign tbl_idx     = item_ff.virt_addr[PAGE_SHIFT +: IDX_W];
   assign slots_full  = (next_slot_ff == NSLOT_W'(TABLE_SLOTS));
   assign new_frame   = table_pool_frame + FRAME_W'(next_slot_ff);
   assign pte_word    = {item_ff.phys_addr[ENTRY_W-1:PAGE_SHIFT],
                         item_ff.page_flags | 12'h001};
   assign pde_word    = {new_frame, 9'd0, item_ff.page_flags[BIT_USER], 2'b11};

   // Output register takes a result when it is empty or being drained.
   assign rsp_load = (state_ff == S_RESP) && (!rsp_valid_ff || !rsp_stall);

   // Sequencer: clearing sweep, directory read, pool access, response.
   always_comb begin
      state_in     = state_ff;
      item_in      = item_ff;
      res_in       = res_ff;
      clr_in       = clr_ff;
      next_slot_in = next_slot_ff;
      req_stall    = 1'b1;
      dir_we       = 1'b0;
      dir_waddr    = item_ff.virt_addr[DIR_SHIFT +: DIR_AW];
      dir_wdata    = '0;
      dir_re       = 1'b0;
      dir_raddr    = req_data.virt_addr[DIR_SHIFT +: DIR_AW];
      pool_we      = 1'b0;
      pool_waddr   = pool_addr(dir_slot, tbl_idx);
      pool_wdata   = '0;
      pool_re      = 1'b0;
      pool_raddr   = pool_addr(dir_slot, tbl_idx);

      case (state_ff)
         S_CLEAR: begin
            // Zero both RAMs; the directory is covered by the low address bits.
            dir_we     = 1'b1;
            dir_waddr  = clr_ff[DIR_AW-1:0];
            pool_we    = 1'b1;
            pool_waddr = clr_ff;
            if (clr_ff == POOL_AW'(POOL_DEPTH - 1)) begin
               state_in = S_IDLE;
            end else begin
               clr_in = clr_ff + 1'b1;
            end
         end
         S_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               item_in  = req_data;
               dir_re   = 1'b1;
               state_in = S_DIR;
            end
         end
         S_DIR: begin
            res_in   = '0;
            state_in = S_RESP;
            case (item_ff.op)
               OP_MAP: begin
                  if (!dir_present) begin
                     if (slots_full) begin
                        res_in.status = STAT_NO_SLOT;
                     end else begin
                        // A fresh slot is still zero from the reset sweep.
                        dir_we       = 1'b1;
                        dir_wdata    = {new_slot, pde_word};
                        pool_we      = 1'b1;
                        pool_waddr   = pool_addr(new_slot, tbl_idx);
                        pool_wdata   = pte_word;
                        next_slot_in = next_slot_ff + 1'b1;
                     end
                  end else begin
                     pool_we    = 1'b1;
                     pool_wdata = pte_word;
                  end
               end
               OP_UNMAP: begin
                  if (!dir_present) begin
                     res_in.status = STAT_ABSENT;
                  end else begin
                     pool_we                = 1'b1;
                     res_in.tlb_invalidate  = 1'b1;
                     res_in.invalidate_addr = item_ff.virt_addr;
                  end
               end
               OP_LOOKUP: begin
                  if (!dir_present) begin
                     res_in.status = STAT_ABSENT;
                  end else begin
                     pool_re  = 1'b1;
                     state_in = S_POOL;
                  end
               end
               default: begin
                  res_in = '0;
               end
            endcase
         end
         S_POOL: begin
            if (pool_rdata[BIT_PRESENT]) begin
               res_in.phys_result = {pool_rdata[ENTRY_W-1:PAGE_SHIFT], 12'h000};
            end else begin
               res_in.status = STAT_ABSENT;
            end
            state_in = S_RESP;
         end
         S_RESP: begin
            if (rsp_load) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Output register next values.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = res_ff;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         next_slot_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         next_slot_ff <= next_slot_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      item_ff     <= item_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Checks on the sequencer.
   `PTM_ASSERT_IMPLY(a_accept_idle, clock, reset, req_valid && !req_stall, state_ff == S_IDLE, "request accepted outside idle")
   `PTM_ASSERT_IMPLY(a_slot_bound, clock, reset, 1'b1, next_slot_ff <= NSLOT_W'(TABLE_SLOTS), "slot counter past pool size")
   `PTM_ASSERT_IMPLY(a_pool_port, clock, reset, pool_we, !pool_re, "pool read and write in one cycle")
   `PTM_ASSERT_NEXT(a_dir_follow, clock, reset, state_ff == S_DIR, state_ff == S_POOL || state_ff == S_RESP, "directory step not followed by pool or response")
   `PTM_ASSERT_IMPLY(a_inv_status, clock, reset, rsp_valid && rsp_data.tlb_invalidate, rsp_data.status == STAT_DONE, "invalidate with failing status")

endmodule
`default_nettype wire

/* sv/ptm_ram.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ptm_ram
// Simple dual-port synchronous RAM with one write port and a registered read.
// ----------------------------------------------------------------------------
module ptm_ram #(
   parameter int DEPTH = 1024,
   parameter int WIDTH = 32,
   localparam int AW   = $clog2(DEPTH)
) (
   input  wire logic             clock,
   input  wire logic             we,
   input  wire logic [AW-1:0]    waddr,
   input  wire logic [WIDTH-1:0] wdata,
   input  wire logic             re,
   input  wire logic [AW-1:0]    raddr,
   output logic      [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
   end

   // Read port, registered.
   always_ff @(posedge clock) begin
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule
`default_nettype wire

/* sv/ptm_csr.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ptm_csr
// Configuration register file: holds the frame number of the first table slot.
// ----------------------------------------------------------------------------
module ptm_csr (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          csr_psel,
   input  wire logic                          csr_penable,
   input  wire logic                          csr_pwrite,
   input  wire logic [ptm_pkg::CSR_AW-1:0]    csr_paddr,
   input  wire logic [ptm_pkg::CSR_DW-1:0]    csr_pwdata,
   output logic      [ptm_pkg::CSR_DW-1:0]    csr_prdata,
   output logic                               csr_pready,
   output logic      [ptm_pkg::FRAME_W-1:0]   table_pool_frame
);
   import ptm_pkg::*;

   logic [FRAME_W-1:0]  frame_ff;
   logic [FRAME_W-1:0]  frame_in;
   logic [CSR_AW-3:0]   reg_idx;
   logic                wr_hit;

   assign reg_idx    = csr_paddr[CSR_AW-1:2];
   assign csr_pready = 1'b1;
   assign wr_hit     = csr_psel && csr_penable && csr_pwrite && csr_pready &&
                       (reg_idx == REG_TABLE_POOL_FRAME);

   // Next value of the frame register.
   always_comb begin
      frame_in = frame_ff;
      if (wr_hit) begin
         frame_in = csr_pwdata[FRAME_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_ff <= FRAME_RESET;
      end else begin
         frame_ff <= frame_in;
      end
   end

   // Read data; addresses past the register file read as zero.
   always_comb begin
      csr_prdata = '0;
      if (reg_idx == REG_TABLE_POOL_FRAME) begin
         csr_prdata = CSR_DW'(frame_ff);
      end
   end

   assign table_pool_frame = frame_ff;

endmodule
`default_nettype wire
